>>> design/rv32ie_pkg.sv
// ============================================================================
// rv32ie_pkg
// Shared types and encodings for the RV32I instruction executor.
// ============================================================================
`default_nettype none

package rv32ie_pkg;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_FAULT   = 3'd2,
        ST_ECALL   = 3'd3,
        ST_EBREAK  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_MEM,
        S_FIN
    } state_t;

    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;
    localparam logic [6:0] OPC_MISC   = 7'h0F;

    localparam logic [6:0] F7_ZERO = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // write request from the executor into the register file
    typedef struct packed {
        logic        en;
        logic [4:0]  addr;
        logic [31:0] data;
    } rf_wr_t;

endpackage

`default_nettype wire

>>> design/rv32ie_rf.sv
// ============================================================================
// rv32ie_rf
// 32x32 register file, two registered read ports, write-first bypass.
// ============================================================================
`default_nettype none

module rv32ie_rf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [4:0]        rd_addr1,
    input  wire logic [4:0]        rd_addr2,
    input  wire rv32ie_pkg::rf_wr_t wr,
    output logic      [31:0]       rd_data1,
    output logic      [31:0]       rd_data2
);

    logic [31:0] mem1 [32];
    logic [31:0] mem2 [32];
    logic [31:0] vld_reg;
    logic [31:0] q1_reg, q2_reg, wdat_reg;
    logic        byp1_reg, byp2_reg, zero1_reg, zero2_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem1[wr.addr] <= wr.data;
            mem2[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            q1_reg   <= mem1[rd_addr1];
            q2_reg   <= mem2[rd_addr2];
            wdat_reg <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            byp1_reg  <= 1'b0;
            byp2_reg  <= 1'b0;
            zero1_reg <= 1'b1;
            zero2_reg <= 1'b1;
        end
        else
        begin
            if (wr.en)
                vld_reg[wr.addr] <= 1'b1;
            if (rd_en)
            begin
                byp1_reg  <= wr.en && (wr.addr == rd_addr1) && (rd_addr1 != 5'd0);
                byp2_reg  <= wr.en && (wr.addr == rd_addr2) && (rd_addr2 != 5'd0);
                zero1_reg <= (rd_addr1 == 5'd0) || !vld_reg[rd_addr1];
                zero2_reg <= (rd_addr2 == 5'd0) || !vld_reg[rd_addr2];
            end
        end
    end

    assign rd_data1 = byp1_reg ? wdat_reg : (zero1_reg ? 32'd0 : q1_reg);
    assign rd_data2 = byp2_reg ? wdat_reg : (zero2_reg ? 32'd0 : q2_reg);

endmodule

`default_nettype wire

>>> design/rv32ie_dmem.sv
// ============================================================================
// rv32ie_dmem
// Byte-wide data memory with a clearing sweep after reset.
// ============================================================================
`default_nettype none

module rv32ie_dmem #(
    parameter int MEM_BYTES = 65536
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         we,
    input  wire logic [$clog2(MEM_BYTES)-1:0] addr,
    input  wire logic [7:0]                   wdata,
    output logic      [7:0]                   rdata,
    output logic                              busy
);

    localparam int AW = $clog2(MEM_BYTES);

    logic [7:0]    mem [MEM_BYTES];
    logic [AW-1:0] clr_cnt_reg;
    logic          clearing_reg;
    logic [7:0]    rdata_reg;
    logic          wen;
    logic [AW-1:0] waddr;
    logic [7:0]    wval;

    assign wen   = clearing_reg || we;
    assign waddr = clearing_reg ? clr_cnt_reg : addr;
    assign wval  = clearing_reg ? 8'd0 : wdata;

    always_ff @(posedge clk)
    begin
        if (wen)
            mem[waddr] <= wval;
        rdata_reg <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clearing_reg <= 1'b1;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == AW'(MEM_BYTES - 1))
                clearing_reg <= 1'b0;
        end
    end

    assign rdata = rdata_reg;
    assign busy  = clearing_reg;

endmodule

`default_nettype wire

>>> design/rv32i_instruction_executor_core.sv
// ============================================================================
// rv32i_instruction_executor_core
// RV32I executor: register file and byte data memory in synchronous RAM.
// ============================================================================
// Usage:
//   Input channel in_valid/in_ready carries one instruction word per request.
//   Output channel out_valid/out_ready returns status, next_pc and the
//   destination write for each request, in order.
//   cfg_we/cfg_wdata write memory_base; write it only while idle.
// Sequence:
//   Non-memory instructions: register file read at acceptance, then execute
//   (S_EXEC), then write-back (S_FIN), where the next request may be accepted.
//   Loads and stores step the byte-wide data memory port once per byte in
//   S_MEM, between execute and write-back.
// Reset:
//   FSM, PC, memory_base, out_valid clear; unwritten registers read zero;
//   the memory is swept to zero one byte a cycle, with in_ready low meanwhile.
// Stalls:
//   A finished result sits in the output register; the next request is
//   accepted and read meanwhile, and waits in write-back until out_ready.
// ============================================================================
`default_nettype none

module rv32i_instruction_executor_core #(
    parameter int MEM_BYTES = 65536
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] instruction,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [31:0]      next_pc,
    output logic             dest_written,
    output logic [4:0]       dest_index,
    output logic [31:0]      dest_value
);

    localparam int AW = $clog2(MEM_BYTES);
    localparam logic [32:0] MEM_SIZE = 33'(MEM_BYTES);

    rv32ie_pkg::state_t  state_reg, state_next;
    rv32ie_pkg::status_t res_status_reg, x_status;
    rv32ie_pkg::rf_wr_t  rf_wr;

    logic [31:0] base_reg, pc_reg, ir_reg;
    logic [31:0] res_npc_reg, res_val_reg, b_reg, ld_reg;
    logic        res_wen_reg, is_load_reg, is_store_reg;
    logic [4:0]  res_idx_reg;
    logic [2:0]  n_reg, bc_reg;
    logic [AW-1:0] idx_reg;

    logic        out_valid_reg, out_wen_reg;
    logic [2:0]  out_status_reg;
    logic [31:0] out_pc_reg, out_val_reg;
    logic [4:0]  out_idx_reg;

    logic [31:0] a, b;
    logic        dm_busy, dm_we;
    logic [7:0]  dm_rdata, dm_wdata;
    logic [AW-1:0] dm_addr;

    logic        accept, slot_free, fin_go;

    // execute-stage decode results
    logic [31:0] x_npc, x_val, x_addr, x_last;
    logic        x_wen, x_mem, x_load, x_store;
    logic [2:0]  x_n;
    logic [32:0] off_first, off_last;

    // memory stage
    logic [31:0] ld_new, ld_ext;
    logic [1:0]  lane;
    logic        mem_done;

    assign slot_free = !out_valid_reg || out_ready;
    assign fin_go    = (state_reg == rv32ie_pkg::S_FIN) && slot_free;
    assign in_ready  = !dm_busy && ((state_reg == rv32ie_pkg::S_IDLE) || fin_go);
    assign accept    = in_valid && in_ready;

    assign rf_wr.en   = fin_go && res_wen_reg;
    assign rf_wr.addr = res_idx_reg;
    assign rf_wr.data = res_val_reg;

    rv32ie_rf u_rf (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr1 (instruction[19:15]),
        .rd_addr2 (instruction[24:20]),
        .wr       (rf_wr),
        .rd_data1 (a),
        .rd_data2 (b)
    );

    rv32ie_dmem #(.MEM_BYTES(MEM_BYTES)) u_dmem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (dm_we),
        .addr  (dm_addr),
        .wdata (dm_wdata),
        .rdata (dm_rdata),
        .busy  (dm_busy)
    );

    // ---------------------------------------------------------------- decode
    always_comb
    begin
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] immi, imms, immb, immj, op2;
        logic [4:0]  sh;
        logic        take, bad;
        logic [31:0] r;

        opc  = ir_reg[6:0];
        f3   = ir_reg[14:12];
        f7   = ir_reg[31:25];
        immi = {{20{ir_reg[31]}}, ir_reg[31:20]};
        imms = {{20{ir_reg[31]}}, ir_reg[31:25], ir_reg[11:7]};
        immb = {{19{ir_reg[31]}}, ir_reg[31], ir_reg[7], ir_reg[30:25],
                ir_reg[11:8], 1'b0};
        immj = {{11{ir_reg[31]}}, ir_reg[31], ir_reg[19:12], ir_reg[20],
                ir_reg[30:21], 1'b0};
        op2  = (opc == rv32ie_pkg::OPC_OP) ? b : immi;
        sh   = op2[4:0];
        take = 1'b0;
        bad  = 1'b0;

        unique case (f3)
            3'd0: r = (opc == rv32ie_pkg::OPC_OP && f7 == rv32ie_pkg::F7_ALT)
                      ? a - op2 : a + op2;
            3'd1: r = a << sh;
            3'd2: r = {31'd0, $signed(a) < $signed(op2)};
            3'd3: r = {31'd0, a < op2};
            3'd4: r = a ^ op2;
            3'd5: r = (f7 == rv32ie_pkg::F7_ALT) ? 32'($signed(a) >>> sh) : a >> sh;
            3'd6: r = a | op2;
            default: r = a & op2;
        endcase

        x_status = rv32ie_pkg::ST_OK;
        x_npc    = pc_reg + 32'd4;
        x_val    = 32'd0;
        x_wen    = 1'b0;
        x_load   = (opc == rv32ie_pkg::OPC_LOAD);
        x_store  = (opc == rv32ie_pkg::OPC_STORE);
        x_addr   = a + (x_store ? imms : immi);
        x_n      = 3'd1 << f3[1:0];
        x_last   = x_addr + 32'(x_n) - 32'd1;
        off_first = {1'b0, x_addr} - {1'b0, base_reg};
        off_last  = {1'b0, x_last} - {1'b0, base_reg};
        x_mem    = 1'b0;

        unique case (opc)
            rv32ie_pkg::OPC_OP:
            begin
                if (f7 != rv32ie_pkg::F7_ZERO &&
                    !(f7 == rv32ie_pkg::F7_ALT && (f3 == 3'd0 || f3 == 3'd5)))
                    x_status = rv32ie_pkg::ST_INVALID;
                else
                begin
                    x_wen = 1'b1;
                    x_val = r;
                end
            end
            rv32ie_pkg::OPC_OPIMM:
            begin
                if (f3 == 3'd1 && f7 != rv32ie_pkg::F7_ZERO)
                    bad = 1'b1;
                if (f3 == 3'd5 && f7 != rv32ie_pkg::F7_ZERO && f7 != rv32ie_pkg::F7_ALT)
                    bad = 1'b1;
                if (bad)
                    x_status = rv32ie_pkg::ST_INVALID;
                else
                begin
                    x_wen = 1'b1;
                    x_val = r;
                end
            end
            rv32ie_pkg::OPC_LOAD, rv32ie_pkg::OPC_STORE:
            begin
                if (x_load)
                    bad = (f3 == 3'd3) || (f3 > 3'd5);
                else
                    bad = (f3 > 3'd2);
                if (bad)
                    x_status = rv32ie_pkg::ST_INVALID;
                else if (off_first[32] || off_first >= MEM_SIZE ||
                         off_last[32] || off_last >= MEM_SIZE)
                    x_status = rv32ie_pkg::ST_FAULT;
                else
                    x_mem = 1'b1;
            end
            rv32ie_pkg::OPC_BRANCH:
            begin
                unique case (f3)
                    3'd0: take = (a == b);
                    3'd1: take = (a != b);
                    3'd4: take = $signed(a) < $signed(b);
                    3'd5: take = !($signed(a) < $signed(b));
                    3'd6: take = (a < b);
                    3'd7: take = (a >= b);
                    default: bad = 1'b1;
                endcase
                if (bad)
                    x_status = rv32ie_pkg::ST_INVALID;
                else if (take)
                begin
                    x_npc = pc_reg + immb;
                    if (x_npc[1:0] != 2'd0)
                        x_status = rv32ie_pkg::ST_FAULT;
                end
            end
            rv32ie_pkg::OPC_JAL:
            begin
                x_wen = 1'b1;
                x_val = pc_reg + 32'd4;
                x_npc = pc_reg + immj;
                if (x_npc[1:0] != 2'd0)
                    x_status = rv32ie_pkg::ST_FAULT;
            end
            rv32ie_pkg::OPC_JALR:
            begin
                if (f3 != 3'd0)
                    x_status = rv32ie_pkg::ST_INVALID;
                else
                begin
                    x_wen = 1'b1;
                    x_val = pc_reg + 32'd4;
                    x_npc = (a + immi) & ~32'd1;
                    if (x_npc[1:0] != 2'd0)
                        x_status = rv32ie_pkg::ST_FAULT;
                end
            end
            rv32ie_pkg::OPC_LUI:
            begin
                x_wen = 1'b1;
                x_val = {ir_reg[31:12], 12'd0};
            end
            rv32ie_pkg::OPC_AUIPC:
            begin
                x_wen = 1'b1;
                x_val = pc_reg + {ir_reg[31:12], 12'd0};
            end
            rv32ie_pkg::OPC_SYSTEM:
            begin
                if (f3 != 3'd0)
                    x_status = rv32ie_pkg::ST_INVALID;
                else if (ir_reg[31:20] == 12'd0)
                    x_status = rv32ie_pkg::ST_ECALL;
                else if (ir_reg[31:20] == 12'd1)
                    x_status = rv32ie_pkg::ST_EBREAK;
                else
                    x_status = rv32ie_pkg::ST_INVALID;
            end
            rv32ie_pkg::OPC_MISC:
            begin
                if (f3 != 3'd0)
                    x_status = rv32ie_pkg::ST_INVALID;
            end
            default: x_status = rv32ie_pkg::ST_INVALID;
        endcase
    end

    // ---------------------------------------------------------- memory step
    assign lane     = 2'(bc_reg - 3'd1);
    assign mem_done = (bc_reg == n_reg);
    assign dm_addr  = idx_reg + AW'(bc_reg);
    assign dm_we    = (state_reg == rv32ie_pkg::S_MEM) && is_store_reg && !mem_done;
    assign dm_wdata = b_reg[8*bc_reg[1:0] +: 8];

    always_comb
    begin
        ld_new = ld_reg;
        if (bc_reg != 3'd0)
            ld_new[8*lane +: 8] = dm_rdata;
        unique case (ir_reg[14:12])
            3'd0:    ld_ext = {{24{ld_new[7]}}, ld_new[7:0]};
            3'd1:    ld_ext = {{16{ld_new[15]}}, ld_new[15:0]};
            3'd4:    ld_ext = {24'd0, ld_new[7:0]};
            3'd5:    ld_ext = {16'd0, ld_new[15:0]};
            default: ld_ext = ld_new;
        endcase
    end

    // ----------------------------------------------------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rv32ie_pkg::S_IDLE: if (accept) state_next = rv32ie_pkg::S_EXEC;
            rv32ie_pkg::S_EXEC: state_next = x_mem ? rv32ie_pkg::S_MEM : rv32ie_pkg::S_FIN;
            rv32ie_pkg::S_MEM:  if (mem_done) state_next = rv32ie_pkg::S_FIN;
            rv32ie_pkg::S_FIN:
            begin
                if (fin_go)
                    state_next = accept ? rv32ie_pkg::S_EXEC : rv32ie_pkg::S_IDLE;
            end
            default: state_next = rv32ie_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rv32ie_pkg::S_IDLE;
            base_reg      <= 32'd0;
            pc_reg        <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                base_reg <= cfg_wdata;
            if (fin_go)
            begin
                out_valid_reg <= 1'b1;
                if (res_status_reg == rv32ie_pkg::ST_OK)
                    pc_reg <= res_npc_reg;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            ir_reg <= instruction;

        if (state_reg == rv32ie_pkg::S_EXEC)
        begin
            res_status_reg <= x_status;
            res_npc_reg    <= x_npc;
            res_wen_reg    <= x_wen && (ir_reg[11:7] != 5'd0);
            res_idx_reg    <= (x_wen && ir_reg[11:7] != 5'd0) ? ir_reg[11:7] : 5'd0;
            res_val_reg    <= (x_wen && ir_reg[11:7] != 5'd0) ? x_val : 32'd0;
            is_load_reg    <= x_load;
            is_store_reg   <= x_store;
            n_reg          <= x_n;
            idx_reg        <= off_first[AW-1:0];
            b_reg          <= b;
            bc_reg         <= 3'd0;
            ld_reg         <= 32'd0;
        end

        if (state_reg == rv32ie_pkg::S_MEM)
        begin
            bc_reg <= bc_reg + 3'd1;
            if (is_load_reg)
                ld_reg <= ld_new;
            if (mem_done && is_load_reg && ir_reg[11:7] != 5'd0)
            begin
                res_wen_reg <= 1'b1;
                res_idx_reg <= ir_reg[11:7];
                res_val_reg <= ld_ext;
            end
        end

        if (fin_go)
        begin
            out_status_reg <= res_status_reg;
            out_pc_reg     <= (res_status_reg == rv32ie_pkg::ST_OK) ? res_npc_reg : pc_reg;
            out_wen_reg    <= res_wen_reg;
            out_idx_reg    <= res_idx_reg;
            out_val_reg    <= res_val_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign next_pc      = out_pc_reg;
    assign dest_written = out_wen_reg;
    assign dest_index   = out_idx_reg;
    assign dest_value   = out_val_reg;

endmodule

`default_nettype wire

>>> design/rv32ie_checker.sv
// ============================================================================
// rv32ie_checker
// Port-level checks on the executor's result channel.
// ============================================================================
`default_nettype none

module rv32ie_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  status,
    input wire logic [31:0] next_pc,
    input wire logic        dest_written,
    input wire logic [4:0]  dest_index,
    input wire logic [31:0] dest_value
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(next_pc) && $stable(dest_value))
        else $error("result changed while stalled");

    a_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !dest_written |-> dest_index == 5'd0 && dest_value == 32'd0)
        else $error("destination fields set without a write");

    a_x0: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dest_written |-> dest_index != 5'd0)
        else $error("write to x0 reported");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= rv32ie_pkg::ST_EBREAK)
        else $error("status code out of range");

    // a write only comes with ok or a faulting jump
    a_wrst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dest_written |->
            status == rv32ie_pkg::ST_OK || status == rv32ie_pkg::ST_FAULT)
        else $error("write reported with trap or invalid status");

endmodule

bind rv32i_instruction_executor_core rv32ie_checker u_rv32ie_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .next_pc      (next_pc),
    .dest_written (dest_written),
    .dest_index   (dest_index),
    .dest_value   (dest_value)
);

`default_nettype wire

>>> bench/tb_rv32i_instruction_executor_core.sv
// ----------------------------------------------------------------------------
// tb_rv32i_instruction_executor_core
// Self-checking bench for the RV32I executor. Instruction words go in over a
// valid/ready channel. A shadow copy of the core state (PC, registers, data
// memory, memory base) predicts each retired result. The results are checked
// in order. Directed cases come first, then random programs. Each program
// keeps two pointer registers aimed at the memory window, so that loads and
// stores hit the window, cross its edges and fault.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rv32i_instruction_executor_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEM_BYTES = 65536;

    localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR = 3'd4, F3_SR = 3'd5, F3_OR = 3'd6, F3_AND = 3'd7;
    localparam logic [2:0] F3_B = 3'd0, F3_H = 3'd1, F3_W = 3'd2, F3_LD_RSV = 3'd3;
    localparam logic [2:0] F3_BU = 3'd4, F3_HU = 3'd5;
    localparam logic [2:0] F3_BEQ = 3'd0, F3_BNE = 3'd1, F3_BLT = 3'd4, F3_BGE = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6, F3_BGEU = 3'd7;
    localparam logic [2:0] F3_JALR = 3'd0, F3_PRIV = 3'd0;
    localparam logic [2:0] F3_FENCE = 3'd0, F3_FENCEI = 3'd1;
    localparam logic [11:0] F12_ECALL = 12'd0, F12_EBREAK = 12'd1;

    typedef struct {
        rv32ie_pkg::status_t st;
        logic [31:0]         npc;
        logic                wr;
        logic [4:0]          idx;
        logic [31:0]         val;
    } retire_t;

    class core_scoreboard;
        logic [31:0] pc;
        logic [31:0] regs [32];
        logic [7:0]  mem [MEM_BYTES];
        logic [31:0] base;
        retire_t     pending_q [$];
        int          errors;

        function void clear();
            pc = '0;
            base = '0;
            foreach (regs[i]) regs[i] = '0;
            foreach (mem[i]) mem[i] = '0;
            errors = 0;
        endfunction

        function bit in_window(logic [31:0] addr);
            return {1'b0, addr} >= {1'b0, base}
                && {1'b0, addr} < {1'b0, base} + 33'(MEM_BYTES);
        endfunction

        function void put_rd(logic [4:0] rd, logic [31:0] v, ref retire_t e);
            if (rd == 0) return;
            regs[rd] = v;
            e.wr = 1'b1;
            e.idx = rd;
            e.val = v;
        endfunction

        function retire_t execute(logic [31:0] ins);
            retire_t     e;
            logic [6:0]  opc, f7;
            logic [4:0]  rd;
            logic [2:0]  f3;
            logic [31:0] a, b, immi, r, addr, last, npc;
            int          n;
            bit          take;
            opc = ins[6:0];
            rd = ins[11:7];
            f3 = ins[14:12];
            f7 = ins[31:25];
            a = (ins[19:15] == 0) ? '0 : regs[ins[19:15]];
            b = (ins[24:20] == 0) ? '0 : regs[ins[24:20]];
            immi = {{20{ins[31]}}, ins[31:20]};
            npc = pc + 4;
            e.st = rv32ie_pkg::ST_OK;
            e.wr = 1'b0;
            e.idx = '0;
            e.val = '0;
            r = '0;
            case (opc)
                rv32ie_pkg::OPC_OP: begin
                    if (f7 != rv32ie_pkg::F7_ZERO &&
                        !(f7 == rv32ie_pkg::F7_ALT && (f3 == F3_ADD || f3 == F3_SR)))
                        e.st = rv32ie_pkg::ST_INVALID;
                    else begin
                        case (f3)
                            F3_ADD:  r = (f7 == rv32ie_pkg::F7_ALT) ? a - b : a + b;
                            F3_SLL:  r = a << b[4:0];
                            F3_SLT:  r = 32'($signed(a) < $signed(b));
                            F3_SLTU: r = 32'(a < b);
                            F3_XOR:  r = a ^ b;
                            F3_SR:   r = (f7 == rv32ie_pkg::F7_ALT)
                                         ? $unsigned($signed(a) >>> b[4:0]) : a >> b[4:0];
                            F3_OR:   r = a | b;
                            default: r = a & b;
                        endcase
                        put_rd(rd, r, e);
                    end
                end
                rv32ie_pkg::OPC_OPIMM: begin
                    case (f3)
                        F3_ADD:  r = a + immi;
                        F3_SLL:  if (f7 != rv32ie_pkg::F7_ZERO) e.st = rv32ie_pkg::ST_INVALID;
                                 else r = a << ins[24:20];
                        F3_SLT:  r = 32'($signed(a) < $signed(immi));
                        F3_SLTU: r = 32'(a < immi);
                        F3_XOR:  r = a ^ immi;
                        F3_SR:   if (f7 == rv32ie_pkg::F7_ZERO) r = a >> ins[24:20];
                                 else if (f7 == rv32ie_pkg::F7_ALT)
                                     r = $unsigned($signed(a) >>> ins[24:20]);
                                 else e.st = rv32ie_pkg::ST_INVALID;
                        F3_OR:   r = a | immi;
                        default: r = a & immi;
                    endcase
                    if (e.st == rv32ie_pkg::ST_OK) put_rd(rd, r, e);
                end
                rv32ie_pkg::OPC_LOAD, rv32ie_pkg::OPC_STORE: begin
                    if (opc == rv32ie_pkg::OPC_LOAD) begin
                        addr = a + immi;
                        if (f3 == F3_LD_RSV || f3 > F3_HU) e.st = rv32ie_pkg::ST_INVALID;
                    end else begin
                        addr = a + {{20{ins[31]}}, ins[31:25], ins[11:7]};
                        if (f3 > F3_W) e.st = rv32ie_pkg::ST_INVALID;
                    end
                    if (e.st == rv32ie_pkg::ST_OK) begin
                        n = 1 << f3[1:0];
                        last = addr + n - 1;
                        if (!in_window(addr) || !in_window(last))
                            e.st = rv32ie_pkg::ST_FAULT;
                        else if (opc == rv32ie_pkg::OPC_STORE) begin
                            for (int k = 0; k < n; k++)
                                mem[16'(addr - base + k)] = b[8*k +: 8];
                        end else begin
                            for (int k = 0; k < n; k++)
                                r[8*k +: 8] = mem[16'(addr - base + k)];
                            if (f3 == F3_B) r = {{24{r[7]}}, r[7:0]};
                            if (f3 == F3_H) r = {{16{r[15]}}, r[15:0]};
                            put_rd(rd, r, e);
                        end
                    end
                end
                rv32ie_pkg::OPC_BRANCH: begin
                    take = 0;
                    case (f3)
                        F3_BEQ:  take = (a == b);
                        F3_BNE:  take = (a != b);
                        F3_BLT:  take = $signed(a) < $signed(b);
                        F3_BGE:  take = $signed(a) >= $signed(b);
                        F3_BLTU: take = a < b;
                        F3_BGEU: take = a >= b;
                        default: e.st = rv32ie_pkg::ST_INVALID;
                    endcase
                    if (take) begin
                        npc = pc + {{19{ins[31]}}, ins[31], ins[7], ins[30:25],
                                    ins[11:8], 1'b0};
                        if (npc[1:0] != 0) e.st = rv32ie_pkg::ST_FAULT;
                    end
                end
                rv32ie_pkg::OPC_JAL: begin
                    put_rd(rd, pc + 4, e);
                    npc = pc + {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
                    if (npc[1:0] != 0) e.st = rv32ie_pkg::ST_FAULT;
                end
                rv32ie_pkg::OPC_JALR: begin
                    if (f3 != F3_JALR) e.st = rv32ie_pkg::ST_INVALID;
                    else begin
                        put_rd(rd, pc + 4, e);
                        npc = (a + immi) & ~32'd1;
                        if (npc[1:0] != 0) e.st = rv32ie_pkg::ST_FAULT;
                    end
                end
                rv32ie_pkg::OPC_LUI:   put_rd(rd, {ins[31:12], 12'd0}, e);
                rv32ie_pkg::OPC_AUIPC: put_rd(rd, pc + {ins[31:12], 12'd0}, e);
                rv32ie_pkg::OPC_SYSTEM: begin
                    if (f3 != F3_PRIV) e.st = rv32ie_pkg::ST_INVALID;
                    else if (ins[31:20] == F12_ECALL) e.st = rv32ie_pkg::ST_ECALL;
                    else if (ins[31:20] == F12_EBREAK) e.st = rv32ie_pkg::ST_EBREAK;
                    else e.st = rv32ie_pkg::ST_INVALID;
                end
                rv32ie_pkg::OPC_MISC: if (f3 != F3_FENCE) e.st = rv32ie_pkg::ST_INVALID;
                default: e.st = rv32ie_pkg::ST_INVALID;
            endcase
            if (e.st == rv32ie_pkg::ST_OK) pc = npc;
            e.npc = pc;
            return e;
        endfunction

        function void note_instruction(logic [31:0] ins);
            pending_q.push_back(execute(ins));
        endfunction

        function void check_retire(logic [2:0] st, logic [31:0] npc, logic wr,
                                   logic [4:0] idx, logic [31:0] val);
            retire_t e;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result: status %0d pc %h", st, npc);
                return;
            end
            e = pending_q.pop_front();
            if (st !== e.st || npc !== e.npc || wr !== e.wr || idx !== e.idx || val !== e.val)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp st %0d pc %h wr %b x%0d=%h got st %0d pc %h wr %b x%0d=%h",
                             e.st, e.npc, e.wr, e.idx, e.val, st, npc, wr, idx, val);
            end
        endfunction
    endclass

    logic        clk, rst_n, cfg_we, in_valid, in_ready, out_valid, out_ready;
    logic        dest_written;
    logic [31:0] cfg_wdata, instruction, next_pc, dest_value;
    logic [2:0]  status;
    logic [4:0]  dest_index;

    core_scoreboard sb;
    int tx_idle, rx_idle;

    rv32i_instruction_executor_core #(.MEM_BYTES(MEM_BYTES)) uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .instruction(instruction),
        .out_valid(out_valid), .out_ready(out_ready), .status(status),
        .next_pc(next_pc), .dest_written(dest_written), .dest_index(dest_index),
        .dest_value(dest_value)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                          logic [4:0] rd, logic [6:0] opc);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], rv32ie_pkg::OPC_STORE};
    endfunction

    function automatic logic [31:0] enc_b(logic [12:0] off, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], rv32ie_pkg::OPC_BRANCH};
    endfunction

    function automatic logic [31:0] enc_j(logic [20:0] off, logic [4:0] rd);
        return {off[20], off[10:1], off[11], off[19:12], rd, rv32ie_pkg::OPC_JAL};
    endfunction

    // hand one request to the core, idling beforehand at the current rate
    task automatic send(logic [31:0] ins);
        while ($urandom_range(99) < tx_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        instruction <= ins;
        do @(posedge clk); while (!in_ready);
        sb.note_instruction(ins);
    endtask

    task automatic load_reg(logic [4:0] rd, logic [31:0] v);
        logic [31:0] hi;
        hi = v + 32'h800;
        send({hi[31:12], rd, rv32ie_pkg::OPC_LUI});
        send(enc_i(v[11:0], rd, F3_ADD, rd, rv32ie_pkg::OPC_OPIMM));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_base(logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.base = v;
    endtask

    function automatic logic [4:0] pick_rd();
        // keep the pointer registers x1/x2 intact most of the time
        if ($urandom_range(19) == 0) return 5'($urandom_range(31));
        return 5'($urandom_range(31, 3));
    endfunction

    function automatic logic [31:0] rand_instr();
        int          c;
        logic [2:0]  f3;
        logic [11:0] imm;
        logic [6:0]  f7;
        c = $urandom_range(99);
        f3 = 3'($urandom_range(7));
        imm = 12'($urandom);
        if (c < 22) begin
            f7 = (f3 == F3_ADD || f3 == F3_SR) && $urandom_range(1)
                 ? rv32ie_pkg::F7_ALT : rv32ie_pkg::F7_ZERO;
            if ($urandom_range(19) == 0) f7 = 7'($urandom);
            return enc_r(f7, 5'($urandom), 5'($urandom), f3, pick_rd(), rv32ie_pkg::OPC_OP);
        end
        if (c < 42) begin
            if (f3 == F3_SLL || f3 == F3_SR) begin
                imm[11:5] = (f3 == F3_SR && $urandom_range(1))
                            ? rv32ie_pkg::F7_ALT : rv32ie_pkg::F7_ZERO;
                if ($urandom_range(19) == 0) imm[11:5] = 7'($urandom);
            end
            return enc_i(imm, 5'($urandom), f3, pick_rd(), rv32ie_pkg::OPC_OPIMM);
        end
        if (c < 66) begin
            imm = 12'($urandom_range(48) - 8);
            if ($urandom_range(9) == 0) imm = 12'($urandom);
            if (c < 54) begin
                f3 = 3'($urandom_range(2));
                if ($urandom_range(9) == 0) f3 = 3'($urandom);
                return enc_s(imm, 5'($urandom), 5'($urandom_range(2, 1)), f3);
            end
            f3 = ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(5));
            return enc_i(imm, 5'($urandom_range(2, 1)), f3, pick_rd(), rv32ie_pkg::OPC_LOAD);
        end
        if (c < 78)
            return enc_b(13'($urandom) & ($urandom_range(7) == 0 ? 13'h1ffe : 13'h1ffc),
                         5'($urandom), 5'($urandom), f3);
        if (c < 83)
            return enc_j(21'($urandom) & ($urandom_range(7) == 0 ? 21'h1ffffe : 21'h1ffffc),
                         pick_rd());
        if (c < 88)
            return enc_i(imm, 5'($urandom), $urandom_range(9) ? F3_JALR : f3, pick_rd(),
                         rv32ie_pkg::OPC_JALR);
        if (c < 93)
            return {20'($urandom), pick_rd(),
                    $urandom_range(1) ? rv32ie_pkg::OPC_LUI : rv32ie_pkg::OPC_AUIPC};
        if (c < 95)
            return enc_i(12'($urandom_range(2)), 5'($urandom), $urandom_range(3) ? F3_PRIV : f3,
                         5'($urandom), rv32ie_pkg::OPC_SYSTEM);
        if (c < 97)
            return enc_i(imm, 5'($urandom), $urandom_range(3) ? F3_FENCE : f3, 5'($urandom),
                         rv32ie_pkg::OPC_MISC);
        return $urandom;
    endfunction

    // results are taken at the edge; ready is redrawn every cycle
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_retire(status, next_pc, dest_written, dest_index, dest_value);
            out_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb_rv32i_instruction_executor_core failed");
        $finish;
    end

    initial
    begin
        logic [31:0] bases [4];
        bases = '{32'h0, 32'hFFFF_FFFF, 32'h1234_5000, 32'hFFFF_0000};
        sb = new();
        sb.clear();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        instruction = '0;
        tx_idle = 32;
        rx_idle = 51;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        do @(posedge clk); while (!in_ready);

        // directed: extremes, the corner cases and each opcode class except AUIPC
        set_base(32'h0);
        send({20'hFFFFF, 5'd3, rv32ie_pkg::OPC_LUI});
        send(enc_i(12'h800, 5'd0, F3_ADD, 5'd4, rv32ie_pkg::OPC_OPIMM));
        send(enc_i(12'h7FF, 5'd0, F3_ADD, 5'd5, rv32ie_pkg::OPC_OPIMM));
        send(enc_r(rv32ie_pkg::F7_ALT, 5'd5, 5'd4, F3_ADD, 5'd6, rv32ie_pkg::OPC_OP));
        send(enc_r(rv32ie_pkg::F7_ALT, 5'd5, 5'd3, F3_SR, 5'd6, rv32ie_pkg::OPC_OP));
        send(enc_r(rv32ie_pkg::F7_ZERO, 5'd5, 5'd4, F3_SLT, 5'd6, rv32ie_pkg::OPC_OP));
        send(enc_r(rv32ie_pkg::F7_ZERO, 5'd5, 5'd4, F3_SLTU, 5'd6, rv32ie_pkg::OPC_OP));
        send(enc_i({rv32ie_pkg::F7_ZERO, 5'd31}, 5'd4, F3_SLL, 5'd7, rv32ie_pkg::OPC_OPIMM));
        send(enc_i({rv32ie_pkg::F7_ALT, 5'd31}, 5'd7, F3_SR, 5'd7, rv32ie_pkg::OPC_OPIMM));
        send(enc_i({7'h01, 5'd3}, 5'd4, F3_SLL, 5'd7, rv32ie_pkg::OPC_OPIMM));
        send(enc_r(7'h01, 5'd5, 5'd4, F3_ADD, 5'd6, rv32ie_pkg::OPC_OP));
        send(enc_s(12'd0, 5'd4, 5'd0, F3_W));
        send(enc_i(12'd0, 5'd0, F3_B, 5'd8, rv32ie_pkg::OPC_LOAD));
        send(enc_i(12'd1, 5'd0, F3_BU, 5'd8, rv32ie_pkg::OPC_LOAD));
        send(enc_i(12'd1, 5'd0, F3_HU, 5'd8, rv32ie_pkg::OPC_LOAD));
        send(enc_i(12'd1, 5'd0, F3_H, 5'd8, rv32ie_pkg::OPC_LOAD));
        send({20'h00010, 5'd9, rv32ie_pkg::OPC_LUI});
        send(enc_i(12'hFFC, 5'd9, F3_W, 5'd8, rv32ie_pkg::OPC_LOAD));
        send(enc_i(12'hFFD, 5'd9, F3_W, 5'd8, rv32ie_pkg::OPC_LOAD));
        send(enc_b(13'd2, 5'd0, 5'd0, F3_BEQ));
        send(enc_j(21'd6, 5'd1));
        send(enc_i(12'd7, 5'd0, F3_JALR, 5'd1, rv32ie_pkg::OPC_JALR));
        send(enc_i(F12_ECALL, 5'd0, F3_PRIV, 5'd0, rv32ie_pkg::OPC_SYSTEM));
        send(enc_i(F12_EBREAK, 5'd0, F3_PRIV, 5'd0, rv32ie_pkg::OPC_SYSTEM));
        send(enc_i(12'd2, 5'd0, F3_PRIV, 5'd0, rv32ie_pkg::OPC_SYSTEM));
        send(enc_i(12'd0, 5'd0, F3_FENCE, 5'd0, rv32ie_pkg::OPC_MISC));
        send(enc_i(12'd0, 5'd0, F3_FENCEI, 5'd0, rv32ie_pkg::OPC_MISC));
        send(32'hFFFF_FFFF);
        send(enc_i(12'h123, 5'd0, F3_ADD, 5'd0, rv32ie_pkg::OPC_OPIMM));

        for (int ph = 0; ph < 4; ph++)
        begin
            drain();
            if (ph == 1) begin tx_idle = 51; rx_idle = 32; end
            if (ph >= 2) begin tx_idle = 0; rx_idle = 0; end
            set_base(bases[ph]);
            for (int i = 0; i < 190; i++)
            begin
                if (i % 50 == 0)
                begin
                    load_reg(5'd1, bases[ph] + 16);
                    load_reg(5'd2, bases[ph] + MEM_BYTES - 24);
                end
                // hold off once until the core has returned everything
                if (ph == 2 && i == 100)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (sb.pending_q.size() != 0) @(posedge clk);
                end
                send(rand_instr());
            end
        end
        drain();

        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("tb_rv32i_instruction_executor_core passed");
        else
            $display("tb_rv32i_instruction_executor_core failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
design/rv32ie_pkg.sv
design/rv32ie_rf.sv
design/rv32ie_dmem.sv
design/rv32i_instruction_executor_core.sv
design/rv32ie_checker.sv
bench/tb_rv32i_instruction_executor_core.sv
